/* rtl/core/ckma_pkg.sv */
package ckma_pkg;

  // Kernel table geometry, fixed by the 6-bit row and column fields
  localparam int TABLE_DIM = 64;
  localparam int TABLE_AW  = 6;
  localparam int KADDR_W   = 2 * TABLE_AW;

  // Fixed-point widths: Q2.15 operands, Q.30 products and sums
  localparam int DATA_W = 18;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = 48;

  // Path length register
  localparam int                LEN_W     = 7;
  localparam logic [LEN_W-1:0]  LEN_RESET = 7'd64;
  localparam int                MAX_LENGTH_DEF = 64;

  // Input item kinds
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } ckma_state_t;

  // Tag that follows one multiply-accumulate through the pipeline
  typedef struct packed {
    logic                valid;
    logic [TABLE_AW-1:0] idx;
    logic                first;
  } ckma_tag_t;

endpackage

/* rtl/core/ckma_kernel_ram.sv */
module ckma_kernel_ram (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ckma_pkg::KADDR_W-1:0]      wr_addr,
  input  logic [ckma_pkg::DATA_W-1:0]       wr_data,
  input  logic [ckma_pkg::KADDR_W-1:0]      rd_addr,
  output logic [ckma_pkg::DATA_W-1:0]       rd_data
);

  localparam int DEPTH = ckma_pkg::TABLE_DIM * ckma_pkg::TABLE_DIM;

  logic [ckma_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/ckma_sum_store.sv */
module ckma_sum_store #(
  parameter int DEPTH = ckma_pkg::MAX_LENGTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [AW-1:0]                rd_idx,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_idx,
  input  logic [ckma_pkg::SUM_W-1:0]   wr_data,
  output logic [ckma_pkg::SUM_W-1:0]   rd_data
);

  logic [ckma_pkg::SUM_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           entry_valid;
  logic [ckma_pkg::SUM_W-1:0] rd_raw;
  logic                       rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_raw <= mem[rd_idx];
  end

  // Entry not written since the last clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      entry_valid <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= entry_valid[rd_idx];
      if (wr_en) begin
        entry_valid[wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

/* rtl/core/ckma_mac.sv */
module ckma_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  ckma_pkg::ckma_tag_t                 tag_in,
  input  logic signed [ckma_pkg::DATA_W-1:0]  inc,
  input  logic [ckma_pkg::DATA_W-1:0]         k_data,
  input  logic [ckma_pkg::SUM_W-1:0]          sum_in,
  output ckma_pkg::ckma_tag_t                 wr_tag,
  output logic [ckma_pkg::SUM_W-1:0]          wr_data,
  output logic                                busy
);

  ckma_pkg::ckma_tag_t                        tag1;
  ckma_pkg::ckma_tag_t                        tag2;
  logic signed [ckma_pkg::PROD_W-1:0]         prod;
  logic [ckma_pkg::SUM_W-1:0]                 sum2;

  // Align tag with registered memory reads, then with the product
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= tag_in;
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ckma_pkg::PROD_W'(inc) * ckma_pkg::PROD_W'($signed(k_data));
    sum2 <= sum_in;
  end

  assign wr_data = sum2 + {{(ckma_pkg::SUM_W - ckma_pkg::PROD_W){prod[ckma_pkg::PROD_W-1]}},
                           prod};
  assign wr_tag  = tag2;
  assign busy    = tag1.valid || tag2.valid;

endmodule

/* rtl/core/causal_kernel_matrix_apply_unit.sv */
// Timing: a sample transaction for step j shows its result after the walk over positions j .. len - 1
//   and the pipeline drain (len = effective path length); a load transaction is written into the kernel table.
// Occupancy: input stalls until a sample's result is emitted; the work is set by the single shared
//   multiply-accumulate that visits one partial sum per cycle plus a three-stage read/multiply/add drain.
// Reset (rst, synchronous, active high): clears partial sums (valid bits), step counter,
//   output valid and sets active_length to 64; the kernel table keeps its contents.
module causal_kernel_matrix_apply_unit #(
  parameter int MAX_LENGTH = ckma_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ckma_pkg::LEN_W-1:0]          cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [ckma_pkg::TABLE_AW-1:0]       kernel_row,
  input  logic [ckma_pkg::TABLE_AW-1:0]       kernel_col,
  input  logic signed [ckma_pkg::DATA_W-1:0]  coefficient,
  input  logic signed [ckma_pkg::DATA_W-1:0]  increment,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ckma_pkg::TABLE_AW-1:0]       position,
  output logic signed [ckma_pkg::SUM_W-1:0]   value,
  output logic                                last_of_path
);

  // Usable path length is bounded by both the parameter and the table size
  localparam int CAP    = (MAX_LENGTH < ckma_pkg::TABLE_DIM) ? MAX_LENGTH
                                                              : ckma_pkg::TABLE_DIM;
  localparam int SUM_AW = $clog2(CAP);
  localparam logic [ckma_pkg::LEN_W-1:0] CAP_LEN = ckma_pkg::LEN_W'(CAP);

  ckma_pkg::ckma_state_t state, state_next;

  // Configuration and path state
  logic [ckma_pkg::LEN_W-1:0]          active_length;
  logic [ckma_pkg::TABLE_AW-1:0]       step_counter;

  // Per-transaction working registers
  logic [ckma_pkg::TABLE_AW-1:0]       j;
  logic [ckma_pkg::TABLE_AW-1:0]       i;
  logic [ckma_pkg::LEN_W-1:0]          len;
  logic signed [ckma_pkg::DATA_W-1:0]  inc;
  logic [ckma_pkg::SUM_W-1:0]          res_value;

  logic [ckma_pkg::LEN_W-1:0]          eff_len;
  logic                                wrap;
  logic                                in_fire;
  logic                                load_fire;
  logic                                sample_fire;
  logic                                last_issue;
  logic                                emit_fire;
  logic                                path_done;
  logic                                sum_clear;

  ckma_pkg::ckma_tag_t                 issue_tag;
  ckma_pkg::ckma_tag_t                 wr_tag;
  logic [ckma_pkg::SUM_W-1:0]          wr_data;
  logic [ckma_pkg::SUM_W-1:0]          sum_rd;
  logic [ckma_pkg::DATA_W-1:0]         k_rd;
  logic                                mac_busy;

  // Configuration is always writable; by contract the user writes it only while the block is idle (unchecked here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= ckma_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_length <= cfg_data;
    end
  end

  // Clamp the configured length to 1 .. CAP
  always_comb begin
    if (active_length == '0) begin
      eff_len = ckma_pkg::LEN_W'(1);
    end else if (active_length > CAP_LEN) begin
      eff_len = CAP_LEN;
    end else begin
      eff_len = active_length;
    end
  end

  // Counter past the end (length shrunk mid-path): restart the path first
  assign wrap = ({1'b0, step_counter} >= eff_len);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ckma_pkg::ST_IDLE: begin
        if (sample_fire) begin
          state_next = ckma_pkg::ST_RUN;
        end
      end
      ckma_pkg::ST_RUN: begin
        if (last_issue) begin
          state_next = ckma_pkg::ST_DRAIN;
        end
      end
      ckma_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ckma_pkg::ST_EMIT;
        end
      end
      ckma_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = ckma_pkg::ST_IDLE;
        end
      end
      default: state_next = ckma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != ckma_pkg::ST_IDLE);
    in_fire         = in_valid && !in_stall;
    load_fire       = in_fire && (action == ckma_pkg::ACT_LOAD);
    sample_fire     = in_fire && (action == ckma_pkg::ACT_SAMPLE);
    last_issue      = (state == ckma_pkg::ST_RUN) &&
                      ({1'b0, i} == (len - ckma_pkg::LEN_W'(1)));
    emit_fire       = (state == ckma_pkg::ST_EMIT) && (!out_valid || !out_stall);
    path_done       = ({1'b0, j} + ckma_pkg::LEN_W'(1)) == len;
    // Start of a wrapped path, or end of the finished one: drop all sums
    sum_clear       = (sample_fire && wrap) || (emit_fire && path_done);
    issue_tag.valid = (state == ckma_pkg::ST_RUN);
    issue_tag.idx   = i;
    issue_tag.first = (i == j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter: advance after each emitted result, restart at path end or on a wrapped sample
  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
    end else if (sample_fire && wrap) begin
      step_counter <= '0;
    end else if (emit_fire) begin
      step_counter <= path_done ? '0 : j + ckma_pkg::TABLE_AW'(1);
    end
  end

  // Capture the transaction and walk i from j up to len - 1
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      j   <= wrap ? '0 : step_counter;
      i   <= wrap ? '0 : step_counter;
      len <= eff_len;
      inc <= increment;
    end else if (state == ckma_pkg::ST_RUN) begin
      i <= i + ckma_pkg::TABLE_AW'(1);
    end
  end

  // Hold the finished sum of position j as it is written back
  always_ff @(posedge clk) begin
    if (wr_tag.valid && wr_tag.first) begin
      res_value <= wr_data;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      position     <= j;
      value        <= $signed(res_value);
      last_of_path <= path_done;
    end
  end

  // ---------------------------------------------------------------- datapath
  ckma_kernel_ram u_kernel_ram (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr ({kernel_row, kernel_col}),
    .wr_data (coefficient),
    .rd_addr ({j, i}),
    .rd_data (k_rd)
  );

  ckma_sum_store #(
    .DEPTH (CAP),
    .AW    (SUM_AW)
  ) u_sum_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (sum_clear),
    .rd_idx  (i[SUM_AW-1:0]),
    .wr_en   (wr_tag.valid),
    .wr_idx  (wr_tag.idx[SUM_AW-1:0]),
    .wr_data (wr_data),
    .rd_data (sum_rd)
  );

  ckma_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (issue_tag),
    .inc     (inc),
    .k_data  (k_rd),
    .sum_in  (sum_rd),
    .wr_tag  (wr_tag),
    .wr_data (wr_data),
    .busy    (mac_busy)
  );

  // ---------------------------------------------------------------- assertions
  // Write-backs happen only while a sample is being worked
  assert property (@(posedge clk) disable iff (rst)
    wr_tag.valid |-> (state == ckma_pkg::ST_RUN || state == ckma_pkg::ST_DRAIN))
    else $error("sum write-back outside of a sample transaction");

  // The pipeline is empty before a result is presented
  assert property (@(posedge clk) disable iff (rst)
    (state == ckma_pkg::ST_EMIT) |-> !mac_busy)
    else $error("result emitted with accumulations in flight");

  // A new result appears only from the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ckma_pkg::ST_EMIT)
    else $error("output valid raised outside the emit step");

  // The walk never visits positions before j or from len on
  assert property (@(posedge clk) disable iff (rst)
    (state == ckma_pkg::ST_RUN) |-> (i >= j && {1'b0, i} < len))
    else $error("partial sum index out of the causal range");

endmodule
